// ----- hdl/jac_pkg.sv -----
// Shared types and constants for the joystick axis conditioner.
`default_nettype none

package jac_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;

    // Result field widths.
    localparam int OUT_BITS = 12;
    localparam int OFS_BITS = 13;

    // Register reset values.
    localparam logic [CFG_DATA_BITS-1:0] HYST_RESET     = 12'd20;
    localparam logic [CFG_DATA_BITS-1:0] DEADZONE_RESET = 12'd200;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_HYSTERESIS = 2'd0,
        REG_DEADZONE   = 2'd1,
        REG_NARROW     = 2'd2
    } cfg_reg_t;

    // Control for the row of tap cells.
    typedef struct packed {
        logic shift;
        logic load_all;
    } cell_ctrl_t;

    // Stage enables for the constant divider.
    typedef struct packed {
        logic load_a;
        logic load_b;
    } div_en_t;

    // Per-item flags that travel with the data through the pipeline.
    typedef struct packed {
        logic calib;
        logic last;
        logic pressed;
    } tag_t;

endpackage

`default_nettype wire

// ----- hdl/joystick_axis_conditioner.sv -----
// Top level: tap-cell filter, calibration, hysteresis hold and activity flag.
//
//  Channel   Direction  Handshake            Payload
//  in        into block in_valid / in_stall  sample_x, sample_y, button_level
//  out       from block out_valid / out_stall filtered_x/y, held_offset_x/y,
//                                            active, calibrated
//  cfg       into block cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low; each result passes through
// stages 0 to 5 and is presented from the stage 5 output register.
// The throughput is set by the hysteresis hold loop in the last stage.
// After the CAL_SAMPLES-th input transfer, input stalls once, until the last
// calibration item has loaded stage 4 and the center has passed its divider.
// Reset clears all control state and the center, and sets the register values to their reset values.
// A stall at the output backs up stage by stage; bubbles are squeezed out.
`default_nettype none

module joystick_axis_conditioner #(
    parameter int FILTER_TAPS = 4,
    parameter int CAL_SAMPLES = 20,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [SAMPLE_BITS-1:0]               sample_x,
    input  logic [SAMPLE_BITS-1:0]               sample_y,
    input  logic                                 button_level,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [jac_pkg::OUT_BITS-1:0]         filtered_x,
    output logic [jac_pkg::OUT_BITS-1:0]         filtered_y,
    output logic signed [jac_pkg::OFS_BITS-1:0]  held_offset_x,
    output logic signed [jac_pkg::OFS_BITS-1:0]  held_offset_y,
    output logic                                 active,
    output logic                                 calibrated,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [jac_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [jac_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import jac_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = SB + $clog2(FILTER_TAPS);
    localparam int CSW   = SB + $clog2(CAL_SAMPLES);
    localparam int CW    = $clog2(CAL_SAMPLES + 1);
    localparam int OW    = SB + 1;
    localparam int CMPW  = (OW + 1 > CFG_DATA_BITS) ? OW + 1 : CFG_DATA_BITS;
    localparam int NSHIFT = SB - 8;
    localparam logic [CW-1:0] CAL_FULL = CW'(CAL_SAMPLES);
    localparam logic [CW-1:0] CAL_LAST = CW'(CAL_SAMPLES - 1);

    // Configuration registers.
    logic [CFG_DATA_BITS-1:0] hyst_reg;
    logic [CFG_DATA_BITS-1:0] dz_reg;
    logic                     narrow_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg   <= HYST_RESET;
            dz_reg     <= DEADZONE_RESET;
            narrow_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_HYSTERESIS: hyst_reg   <= cfg_data;
                REG_DEADZONE:   dz_reg     <= cfg_data;
                REG_NARROW:     narrow_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Stage valids and enables; a stage loads when empty or when it drains.
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en0, en1, en2, en3, en4, en5;
    logic accept;
    logic cal_wait;

    assign en5 = !v5_reg || !out_stall;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;

    assign in_stall  = !en0 || cal_wait;
    assign accept    = in_valid && !in_stall;
    assign out_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= accept;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Input-side calibration count and prefill flag.
    logic [CW-1:0] in_cnt_reg;
    logic          ring_primed_reg;
    logic          center_ready_reg;

    assign cal_wait = (in_cnt_reg == CAL_FULL) && !center_ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg      <= '0;
            ring_primed_reg <= 1'b0;
        end
        else if (accept)
        begin
            ring_primed_reg <= 1'b1;
            if (in_cnt_reg != CAL_FULL)
            begin
                in_cnt_reg <= in_cnt_reg + CW'(1);
            end
        end
    end

    // Stage 0: row of tap cells, shared by both axes.
    cell_ctrl_t   cell_ctrl;
    logic [SB-1:0] tap_x [FILTER_TAPS];
    logic [SB-1:0] tap_y [FILTER_TAPS];
    tag_t          tag0_reg, tag1_reg, tag2_reg, tag3_reg, tag4_reg;

    assign cell_ctrl.shift    = accept;
    assign cell_ctrl.load_all = !ring_primed_reg;

    for (genvar g = 0; g < FILTER_TAPS; g++)
    begin : g_cell
        logic [SB-1:0] prev_x;
        logic [SB-1:0] prev_y;

        if (g == 0)
        begin : g_head
            assign prev_x = sample_x;
            assign prev_y = sample_y;
        end
        else
        begin : g_body
            assign prev_x = tap_x[g-1];
            assign prev_y = tap_y[g-1];
        end

        jac_tap_cell #(
            .W (SB)
        ) u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .sample_x (sample_x),
            .sample_y (sample_y),
            .prev_x   (prev_x),
            .prev_y   (prev_y),
            .tap_x    (tap_x[g]),
            .tap_y    (tap_y[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag0_reg.calib   <= (in_cnt_reg != CAL_FULL);
            tag0_reg.last    <= (in_cnt_reg == CAL_LAST);
            tag0_reg.pressed <= !button_level;
        end
    end

    // Stage 1: sum over the taps.
    logic [AW-1:0] sum_x, sum_y;
    logic [AW-1:0] sum_x_reg, sum_y_reg;

    always_comb
    begin
        sum_x = '0;
        sum_y = '0;
        for (int i = 0; i < FILTER_TAPS; i++)
        begin
            sum_x = sum_x + AW'(tap_x[i]);
            sum_y = sum_y + AW'(tap_y[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && v0_reg)
        begin
            sum_x_reg <= sum_x;
            sum_y_reg <= sum_y;
            tag1_reg  <= tag0_reg;
        end
    end

    // Stages 2 and 3: average by dividing the sum by the tap count.
    div_en_t       avg_en;
    logic [SB-1:0] fx, fy;

    assign avg_en.load_a = en2;
    assign avg_en.load_b = en3;

    jac_cdiv #(
        .NW      (AW),
        .QW      (SB),
        .DIVISOR (FILTER_TAPS)
    ) u_avg_x (
        .clk      (clk),
        .en       (avg_en),
        .dividend (sum_x_reg),
        .quotient (fx)
    );

    jac_cdiv #(
        .NW      (AW),
        .QW      (SB),
        .DIVISOR (FILTER_TAPS)
    ) u_avg_y (
        .clk      (clk),
        .en       (avg_en),
        .dividend (sum_y_reg),
        .quotient (fy)
    );

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg) tag2_reg <= tag1_reg;
        if (en3 && v2_reg) tag3_reg <= tag2_reg;
    end

    // Stage 4: calibration sums, offsets from center, deadzone test on offsets.
    logic                 load4;
    logic [CSW-1:0]       cal_sum_x_reg, cal_sum_y_reg;
    logic [SB-1:0]        center_x_reg, center_y_reg;
    logic [SB-1:0]        f4_x_reg, f4_y_reg;
    logic signed [OW-1:0] off_x, off_y;
    logic [OW-1:0]        aoff_x, aoff_y;
    logic signed [OW-1:0] off4_x_reg, off4_y_reg;
    logic                 dzo4_x_reg, dzo4_y_reg;

    assign load4 = en4 && v3_reg;

    always_comb
    begin
        off_x  = $signed({1'b0, fx}) - $signed({1'b0, center_x_reg});
        off_y  = $signed({1'b0, fy}) - $signed({1'b0, center_y_reg});
        aoff_x = off_x[OW-1] ? OW'(-off_x) : OW'(off_x);
        aoff_y = off_y[OW-1] ? OW'(-off_y) : OW'(off_y);
    end

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            f4_x_reg   <= fx;
            f4_y_reg   <= fy;
            off4_x_reg <= off_x;
            off4_y_reg <= off_y;
            dzo4_x_reg <= CMPW'(aoff_x) > CMPW'(dz_reg);
            dzo4_y_reg <= CMPW'(aoff_y) > CMPW'(dz_reg);
            tag4_reg   <= tag3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_sum_x_reg <= '0;
            cal_sum_y_reg <= '0;
        end
        else if (load4 && tag3_reg.calib)
        begin
            cal_sum_x_reg <= cal_sum_x_reg + CSW'(fx);
            cal_sum_y_reg <= cal_sum_y_reg + CSW'(fy);
        end
    end

    // Center divider runs freely; a short valid chain marks its result.
    logic          cv0_reg, cv1_reg, cv2_reg;
    div_en_t       ctr_en;
    logic [SB-1:0] ctr_x, ctr_y;

    assign ctr_en.load_a = 1'b1;
    assign ctr_en.load_b = 1'b1;

    jac_cdiv #(
        .NW      (CSW),
        .QW      (SB),
        .DIVISOR (CAL_SAMPLES)
    ) u_ctr_x (
        .clk      (clk),
        .en       (ctr_en),
        .dividend (cal_sum_x_reg),
        .quotient (ctr_x)
    );

    jac_cdiv #(
        .NW      (CSW),
        .QW      (SB),
        .DIVISOR (CAL_SAMPLES)
    ) u_ctr_y (
        .clk      (clk),
        .en       (ctr_en),
        .dividend (cal_sum_y_reg),
        .quotient (ctr_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv0_reg          <= 1'b0;
            cv1_reg          <= 1'b0;
            cv2_reg          <= 1'b0;
            center_ready_reg <= 1'b0;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
        end
        else
        begin
            cv0_reg <= load4 && tag3_reg.last;
            cv1_reg <= cv0_reg;
            cv2_reg <= cv1_reg;
            if (cv2_reg)
            begin
                center_x_reg     <= ctr_x;
                center_y_reg     <= ctr_y;
                center_ready_reg <= 1'b1;
            end
        end
    end

    // Stage 5: hysteresis hold, activity and the output register.
    logic                 load5;
    logic                 hold_primed_reg;
    logic signed [OW-1:0] held_x_reg, held_y_reg;
    logic signed [OW-1:0] held_x_next, held_y_next;
    logic signed [OW:0]   dif_x, dif_y;
    logic [OW:0]          adif_x, adif_y;
    logic [OW-1:0]        aheld_x, aheld_y;
    logic                 over_x, over_y;
    logic                 move_x, move_y;
    logic [SB-1:0]        ox, oy;

    assign load5 = en5 && v4_reg;

    always_comb
    begin
        dif_x   = $signed({off4_x_reg[OW-1], off4_x_reg})
                - $signed({held_x_reg[OW-1], held_x_reg});
        dif_y   = $signed({off4_y_reg[OW-1], off4_y_reg})
                - $signed({held_y_reg[OW-1], held_y_reg});
        adif_x  = dif_x[OW] ? (OW+1)'(-dif_x) : (OW+1)'(dif_x);
        adif_y  = dif_y[OW] ? (OW+1)'(-dif_y) : (OW+1)'(dif_y);
        aheld_x = held_x_reg[OW-1] ? OW'(-held_x_reg) : OW'(held_x_reg);
        aheld_y = held_y_reg[OW-1] ? OW'(-held_y_reg) : OW'(held_y_reg);

        // The first calibrated item takes the offsets directly.
        move_x = !hold_primed_reg || (CMPW'(adif_x) > CMPW'(hyst_reg));
        move_y = !hold_primed_reg || (CMPW'(adif_y) > CMPW'(hyst_reg));

        held_x_next = move_x ? off4_x_reg : held_x_reg;
        held_y_next = move_y ? off4_y_reg : held_y_reg;
        over_x      = move_x ? dzo4_x_reg : (CMPW'(aheld_x) > CMPW'(dz_reg));
        over_y      = move_y ? dzo4_y_reg : (CMPW'(aheld_y) > CMPW'(dz_reg));

        ox = narrow_reg ? (f4_x_reg >> NSHIFT) : f4_x_reg;
        oy = narrow_reg ? (f4_y_reg >> NSHIFT) : f4_y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_primed_reg <= 1'b0;
            held_x_reg      <= '0;
            held_y_reg      <= '0;
        end
        else if (load5 && !tag4_reg.calib)
        begin
            hold_primed_reg <= 1'b1;
            held_x_reg      <= held_x_next;
            held_y_reg      <= held_y_next;
        end
    end

    logic [OUT_BITS-1:0]        filtered_x_reg, filtered_y_reg;
    logic signed [OFS_BITS-1:0] held_offset_x_reg, held_offset_y_reg;
    logic                       active_reg, calibrated_reg;

    always_ff @(posedge clk)
    begin
        if (load5)
        begin
            filtered_x_reg <= OUT_BITS'(ox);
            filtered_y_reg <= OUT_BITS'(oy);
            if (tag4_reg.calib)
            begin
                held_offset_x_reg <= '0;
                held_offset_y_reg <= '0;
                active_reg        <= 1'b0;
                calibrated_reg    <= 1'b0;
            end
            else
            begin
                held_offset_x_reg <= OFS_BITS'(held_x_next);
                held_offset_y_reg <= OFS_BITS'(held_y_next);
                active_reg        <= over_x || over_y || tag4_reg.pressed;
                calibrated_reg    <= 1'b1;
            end
        end
    end

    assign filtered_x    = filtered_x_reg;
    assign filtered_y    = filtered_y_reg;
    assign held_offset_x = held_offset_x_reg;
    assign held_offset_y = held_offset_y_reg;
    assign active        = active_reg;
    assign calibrated    = calibrated_reg;

    // A calibrated result can only come after the center is fixed.
    a_cal_after_center: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && calibrated |-> center_ready_reg)
        else $error("calibrated result before center was fixed");

    // Results taken during calibration carry no offsets and no activity.
    a_cal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !calibrated |->
            held_offset_x == '0 && held_offset_y == '0 && !active)
        else $error("calibrating result carries offsets or activity");

    // Once fixed, the center stays valid until reset.
    a_center_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        center_ready_reg |=> center_ready_reg)
        else $error("center ready flag dropped");

    // No input transfer after the last calibration sample until the center is fixed.
    a_wait_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_cnt_reg == CAL_FULL) && !center_ready_reg |-> !accept)
        else $error("input transfer while center pending");

endmodule

`default_nettype wire

// ----- hdl/jac_tap_cell.sv -----
// One filter tap cell holding an X and a Y sample.
`default_nettype none

module jac_tap_cell #(
    parameter int W = 12
) (
    input  logic                 clk,
    input  jac_pkg::cell_ctrl_t  ctrl,
    input  logic [W-1:0]         sample_x,
    input  logic [W-1:0]         sample_y,
    input  logic [W-1:0]         prev_x,
    input  logic [W-1:0]         prev_y,
    output logic [W-1:0]         tap_x,
    output logic [W-1:0]         tap_y
);
    import jac_pkg::*;

    logic [W-1:0] tap_x_reg;
    logic [W-1:0] tap_y_reg;
    logic [W-1:0] tap_x_next;
    logic [W-1:0] tap_y_next;

    // The first sample fills every tap; later ones move one cell along.
    always_comb
    begin
        tap_x_next = ctrl.load_all ? sample_x : prev_x;
        tap_y_next = ctrl.load_all ? sample_y : prev_y;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            tap_x_reg <= tap_x_next;
            tap_y_reg <= tap_y_next;
        end
    end

    assign tap_x = tap_x_reg;
    assign tap_y = tap_y_reg;

endmodule

`default_nettype wire

// ----- hdl/jac_cdiv.sv -----
// Two-stage divider by a constant using a reciprocal product and one correction.
`default_nettype none

module jac_cdiv #(
    parameter int NW      = 14,
    parameter int QW      = 12,
    parameter int DIVISOR = 4
) (
    input  logic              clk,
    input  jac_pkg::div_en_t  en,
    input  logic [NW-1:0]     dividend,
    output logic [QW-1:0]     quotient
);
    import jac_pkg::*;

    localparam logic [NW:0]   RECIP = (NW+1)'((2**NW) / DIVISOR);
    localparam logic [NW-1:0] DIV_C = NW'(DIVISOR);

    logic [NW-1:0]   num_reg;
    logic [2*NW:0]   prod_reg;
    logic [2*NW:0]   prod_next;
    logic [NW-1:0]   q_est;
    logic [2*NW-1:0] q_times_d;
    logic [NW-1:0]   rem;
    logic [NW-1:0]   q_fix;
    logic [QW-1:0]   quotient_reg;

    // Stage a: product with the truncated reciprocal.
    assign prod_next = (2*NW+1)'(dividend) * (2*NW+1)'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            num_reg  <= dividend;
            prod_reg <= prod_next;
        end
    end

    // Stage b: the estimate is at most one low, so one compare fixes it.
    always_comb
    begin
        q_est     = prod_reg[2*NW-1:NW];
        q_times_d = (2*NW)'(q_est) * (2*NW)'(DIV_C);
        rem       = num_reg - q_times_d[NW-1:0];
        q_fix     = (rem >= DIV_C) ? q_est + NW'(1) : q_est;
    end

    always_ff @(posedge clk)
    begin
        if (en.load_b)
        begin
            quotient_reg <= QW'(q_fix);
        end
    end

    assign quotient = quotient_reg;

endmodule

`default_nettype wire

// ----- dv/jac_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard with the expected-reading model for the joystick axis conditioner bench.
package jac_tb_pkg;

    import jac_pkg::*;

    // Geometry of the block as built in this bench.
    localparam int TAPS         = 4;
    localparam int CAL_COUNT    = 20;
    localparam int NARROW_SHIFT = 4;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    // One result item as seen on the output channel.
    typedef struct packed {
        logic [OUT_BITS-1:0]        filt_x;
        logic [OUT_BITS-1:0]        filt_y;
        logic signed [OFS_BITS-1:0] hold_x;
        logic signed [OFS_BITS-1:0] hold_y;
        logic                       act;
        logic                       cal;
    } reading_t;

    class axis_scoreboard;

        // Register copies.
        logic [CFG_DATA_BITS-1:0] hyst;
        logic [CFG_DATA_BITS-1:0] dead;
        logic                     narrow;

        // Filter, calibration and hold state.
        int  taps_x [TAPS];
        int  taps_y [TAPS];
        int  wr_pos;
        bit  taps_filled;
        int  cal_seen;
        int  sum_x;
        int  sum_y;
        int  mid_x;
        int  mid_y;
        int  keep_x;
        int  keep_y;
        bit  hold_primed;

        reading_t expected_readings[$];
        int       errors;

        function new();
            hyst        = HYST_RESET;
            dead        = DEADZONE_RESET;
            narrow      = 1'b0;
            foreach (taps_x[i])
            begin
                taps_x[i] = 0;
                taps_y[i] = 0;
            end
            wr_pos      = 0;
            taps_filled = 1'b0;
            cal_seen    = 0;
            sum_x       = 0;
            sum_y       = 0;
            mid_x       = 0;
            mid_y       = 0;
            keep_x      = 0;
            keep_y      = 0;
            hold_primed = 1'b0;
            errors      = 0;
        endfunction

        // Track a register write; unknown indexes leave everything alone.
        function void set_register(logic [CFG_IDX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_HYSTERESIS: hyst = data;
                REG_DEADZONE:   dead = data;
                REG_NARROW:     narrow = data[0];
                default:        ;
            endcase
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // Advance the model by one accepted sample pair and queue its reading.
        function void note_sample(logic [OUT_BITS-1:0] sx, logic [OUT_BITS-1:0] sy,
                                  logic btn);
            int       fx;
            int       fy;
            int       off_x;
            int       off_y;
            reading_t r;

            // The first sample fills every tap; later ones overwrite the oldest tap.
            if (!taps_filled)
            begin
                foreach (taps_x[i])
                begin
                    taps_x[i] = sx;
                    taps_y[i] = sy;
                end
                taps_filled = 1'b1;
            end
            else
            begin
                taps_x[wr_pos] = sx;
                taps_y[wr_pos] = sy;
            end
            wr_pos = (wr_pos + 1) % TAPS;

            fx = 0;
            fy = 0;
            foreach (taps_x[i])
            begin
                fx += taps_x[i];
                fy += taps_y[i];
            end
            fx = fx / TAPS;
            fy = fy / TAPS;

            r = '0;
            if (cal_seen < CAL_COUNT)
            begin
                // Calibration: full-width averages feed the center sums.
                sum_x += fx;
                sum_y += fy;
                cal_seen++;
                if (cal_seen == CAL_COUNT)
                begin
                    mid_x = sum_x / CAL_COUNT;
                    mid_y = sum_y / CAL_COUNT;
                end
            end
            else
            begin
                off_x = fx - mid_x;
                off_y = fy - mid_y;
                // The first calibrated item primes the hold directly.
                if (!hold_primed)
                begin
                    keep_x      = off_x;
                    keep_y      = off_y;
                    hold_primed = 1'b1;
                end
                else
                begin
                    if (magnitude(off_x - keep_x) > hyst)
                        keep_x = off_x;
                    if (magnitude(off_y - keep_y) > hyst)
                        keep_y = off_y;
                end
                r.hold_x = keep_x[OFS_BITS-1:0];
                r.hold_y = keep_y[OFS_BITS-1:0];
                r.act    = (magnitude(keep_x) > dead) || (magnitude(keep_y) > dead) || !btn;
                r.cal    = 1'b1;
            end

            r.filt_x = narrow ? fx[OUT_BITS-1:0] >> NARROW_SHIFT : fx[OUT_BITS-1:0];
            r.filt_y = narrow ? fy[OUT_BITS-1:0] >> NARROW_SHIFT : fy[OUT_BITS-1:0];
            expected_readings.push_back(r);
        endfunction

        // Compare one output transfer with the oldest outstanding reading.
        function void check_reading(reading_t got);
            reading_t want;

            if (expected_readings.size() == 0)
            begin
                $error("result transfer with no reading outstanding");
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            if (got.filt_x !== want.filt_x)
            begin
                $error("filtered_x: expected %0d, got %0d", want.filt_x, got.filt_x);
                errors++;
            end
            if (got.filt_y !== want.filt_y)
            begin
                $error("filtered_y: expected %0d, got %0d", want.filt_y, got.filt_y);
                errors++;
            end
            if (got.hold_x !== want.hold_x)
            begin
                $error("held_offset_x: expected %0d, got %0d", want.hold_x, got.hold_x);
                errors++;
            end
            if (got.hold_y !== want.hold_y)
            begin
                $error("held_offset_y: expected %0d, got %0d", want.hold_y, got.hold_y);
                errors++;
            end
            if (got.act !== want.act)
            begin
                $error("active: expected %0d, got %0d", want.act, got.act);
                errors++;
            end
            if (got.cal !== want.cal)
            begin
                $error("calibrated: expected %0d, got %0d", want.cal, got.cal);
                errors++;
            end
        endfunction

    endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench: drives samples and register writes, checks every result.
module tb_top;

    import jac_pkg::*;
    import jac_tb_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int SETTLE_CYCLES = 20;
    localparam int SAMPLE_MAX    = 4095;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic [OUT_BITS-1:0]         sample_x     = '0;
    logic [OUT_BITS-1:0]         sample_y     = '0;
    logic                        button_level = 1'b1;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic [OUT_BITS-1:0]         filtered_x;
    logic [OUT_BITS-1:0]         filtered_y;
    logic signed [OFS_BITS-1:0]  held_offset_x;
    logic signed [OFS_BITS-1:0]  held_offset_y;
    logic                        active;
    logic                        calibrated;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_BITS-1:0]     cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data     = '0;

    axis_scoreboard board;
    int             in_calm  = 0;
    int             out_calm = 0;
    int             quiet    = 0;

    always #5 clk = ~clk;

    joystick_axis_conditioner dut (.*);

    // Gap before the next transfer; now and then a run of back-to-back transfers.
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(5, 30);
        return $urandom_range(0, 9);
    endfunction

    function automatic int clamp_sample(int v);
        return (v < 0) ? 0 : ((v > SAMPLE_MAX) ? SAMPLE_MAX : v);
    endfunction

    // Present one sample pair and wait for its transfer.
    task push_sample(input logic [OUT_BITS-1:0] x, input logic [OUT_BITS-1:0] y,
                     input logic btn);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_x     <= x;
        sample_y     <= y;
        button_level <= btn;
        do @(posedge clk); while (in_stall);
        board.note_sample(x, y, btn);
    endtask

    // One register write; valid drops for a cycle so writes never merge.
    task write_register(input logic [CFG_IDX_BITS-1:0] idx,
                        input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_register(idx, data);
        @(posedge clk);
    endtask

    // Wait until every outstanding reading has come back, then let the pipe settle.
    task drain_results;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random stalls per item, check every transfer.
    initial
    begin
        int       n;
        reading_t got;
        @(posedge rst_n);
        forever
        begin
            n = draw_gap(out_calm);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            got = {filtered_x, filtered_y, held_offset_x, held_offset_y, active, calibrated};
            board.check_reading(got);
        end
    end

    // Watchdog: end the run if no channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus: directed calibration and hold cases, then random phases.
    initial
    begin
        int                       p;
        int                       i;
        int                       pick;
        int                       walk_x;
        int                       walk_y;
        logic [CFG_DATA_BITS-1:0] hyst_val;
        logic [CFG_DATA_BITS-1:0] dead_val;
        logic                     narrow_val;

        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A write to the spare index must change nothing; narrow mode is on
        // during calibration, which must still use full-width averages.
        write_register(REG_SPARE, 12'hFFF);
        write_register(REG_NARROW, 12'd1);

        // Calibration items: extremes first (the first one fills the taps),
        // with the button pressed on some of them, which must not raise active yet.
        push_sample(12'hFFF, 12'h000, 1'b0);
        push_sample(12'h000, 12'hFFF, 1'b1);
        push_sample(12'hAAA, 12'h555, 1'b0);
        push_sample(12'h555, 12'hAAA, 1'b1);
        for (i = 0; i < CAL_COUNT - 4; i++)
            push_sample(12'(2000 + i * 8), 12'(2100 - i * 8), i[0]);

        // First calibrated item primes the hold, then full-scale swings.
        push_sample(12'd2048, 12'd2048, 1'b1);
        push_sample(12'hFFF, 12'hFFF, 1'b1);
        push_sample(12'h000, 12'h000, 1'b1);
        push_sample(12'd2048, 12'd2048, 1'b0);
        in_valid <= 1'b0;
        drain_results();

        // Random phases, each under its own register setting.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
            begin
                hyst_val   = '0;
                dead_val   = '0;
                narrow_val = 1'b0;
            end
            else if (p == 1)
            begin
                hyst_val   = 12'hFFF;
                dead_val   = 12'hFFF;
                narrow_val = 1'b1;
            end
            else
            begin
                hyst_val   = 12'($urandom_range(0, 80));
                dead_val   = 12'($urandom_range(0, 500));
                narrow_val = 1'($urandom_range(0, 1));
            end
            write_register(REG_HYSTERESIS, hyst_val);
            write_register(REG_DEADZONE, dead_val);
            write_register(REG_NARROW, {11'd0, narrow_val});
            if (p == 3)
                write_register(REG_SPARE, 12'($urandom));

            // Mostly a slow walk around the center, with jumps and raw noise.
            walk_x = board.mid_x;
            walk_y = board.mid_y;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    push_sample(12'($urandom), 12'($urandom), 1'($urandom));
                else
                begin
                    if (pick < 20)
                    begin
                        walk_x = board.mid_x + int'($urandom_range(0, 1200)) - 600;
                        walk_y = board.mid_y + int'($urandom_range(0, 1200)) - 600;
                    end
                    walk_x = clamp_sample(walk_x + int'($urandom_range(0, 80)) - 40);
                    walk_y = clamp_sample(walk_y + int'($urandom_range(0, 80)) - 40);
                    push_sample(12'(walk_x), 12'(walk_y), $urandom_range(0, 7) != 0);
                end
            end
            in_valid <= 1'b0;
            drain_results();
        end

        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
